// File: hw/rtl/lbi_pkg.sv
// ----------------------------------------------------------------------------
// lbi_pkg: shared types and codes for the interpolator
// Request and result layouts and the request type codes.
// ----------------------------------------------------------------------------
package lbi_pkg;

  localparam int DATA_W = 16;

  localparam logic [1:0] REQ_LINEAR   = 2'd0;
  localparam logic [1:0] REQ_BILINEAR = 2'd1;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] x_pos;
    logic signed [DATA_W-1:0] y_pos;
    logic signed [DATA_W-1:0] x_low;
    logic signed [DATA_W-1:0] x_high;
    logic signed [DATA_W-1:0] y_low;
    logic signed [DATA_W-1:0] y_high;
    logic signed [DATA_W-1:0] f_00;
    logic signed [DATA_W-1:0] f_10;
    logic signed [DATA_W-1:0] f_01;
    logic signed [DATA_W-1:0] f_11;
  } lbi_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interp_value;
    logic                     zero_width;
    logic                     saturated;
  } lbi_res_t;

endpackage

// File: hw/rtl/linear_bilinear_interpolator_top.sv
// ----------------------------------------------------------------------------
// linear_bilinear_interpolator_top: linear / bilinear interpolator
// Two x passes run side by side, their results feed one y pass.
//
//   channel  direction  handshake             payload
//   in_      request    in_valid / in_stall   lbi_req_t
//   out_     result     out_valid / out_stall lbi_res_t
//
// One request enters per cycle while in_stall is low; the pipeline depth is set
// by the one-bit-per-stage dividers of the two chained passes.
// Reset clears only the valid bits of the stages.
// The whole pipeline advances together; it holds while the result register
// is full and stalled, and in_stall follows from that.
// ----------------------------------------------------------------------------
module linear_bilinear_interpolator_top import lbi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lbi_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output lbi_res_t out_data
);

  localparam int W    = DATA_W;
  localparam int XSBW = 3 + 3 * W;
  localparam int YSBW = 5 + W;

  logic     out_v_r;
  lbi_res_t out_r;
  logic     en;

  // advance everything unless the result register is held
  assign en       = !out_v_r || !out_stall;
  assign in_stall = !en;

  // flag a zero-width interval on entry
  logic zw_in;

  always_comb begin
    unique case (in_data.req_type)
      REQ_LINEAR:   zw_in = in_data.x_high == in_data.x_low;
      REQ_BILINEAR: zw_in = (in_data.x_high == in_data.x_low) ||
                            (in_data.y_high == in_data.y_low);
      default:      zw_in = 1'b0;
    endcase
  end

  // x passes at y_low and y_high
  logic [XSBW-1:0] xsb_in, xsb_out, xsb_unused;
  logic            xa_v, xb_v;
  logic [W-1:0]    xa_val, xb_val;
  logic            xa_sat, xb_sat;

  assign xsb_in = {in_data.req_type, zw_in, in_data.y_pos, in_data.y_low, in_data.y_high};

  lbi_pass #(.DATA_WIDTH(W), .SB_WIDTH(XSBW)) u_pass_xa (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .f0       (in_data.f_00),
    .f1       (in_data.f_10),
    .p        (in_data.x_pos),
    .lo       (in_data.x_low),
    .hi       (in_data.x_high),
    .sb_in    (xsb_in),
    .out_valid(xa_v),
    .val      (xa_val),
    .sat      (xa_sat),
    .sb_out   (xsb_out)
  );

  lbi_pass #(.DATA_WIDTH(W), .SB_WIDTH(XSBW)) u_pass_xb (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .f0       (in_data.f_01),
    .f1       (in_data.f_11),
    .p        (in_data.x_pos),
    .lo       (in_data.x_low),
    .hi       (in_data.x_high),
    .sb_in    (xsb_in),
    .out_valid(xb_v),
    .val      (xb_val),
    .sat      (xb_sat),
    .sb_out   (xsb_unused)
  );

  // y pass over the two x results; carry the linear result alongside
  logic [1:0]      x_mode;
  logic            x_zw;
  logic [W-1:0]    x_y, x_y0, x_y1;
  logic [YSBW-1:0] ysb_in, ysb_out;
  logic            y_v, y_sat;
  logic [W-1:0]    y_val;

  assign {x_mode, x_zw, x_y, x_y0, x_y1} = xsb_out;
  assign ysb_in = {x_mode, x_zw, xa_sat | xb_sat, xa_sat, xa_val};

  lbi_pass #(.DATA_WIDTH(W), .SB_WIDTH(YSBW)) u_pass_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (xa_v & xb_v & (xsb_unused == xsb_out)),
    .f0       (xa_val),
    .f1       (xb_val),
    .p        (x_y),
    .lo       (x_y0),
    .hi       (x_y1),
    .sb_in    (ysb_in),
    .out_valid(y_v),
    .val      (y_val),
    .sat      (y_sat),
    .sb_out   (ysb_out)
  );

  // pick the result by request type
  logic [1:0]   r_mode;
  logic         r_zw, r_xsat, r_asat;
  logic [W-1:0] r_aval;
  lbi_res_t     res_nxt;

  assign {r_mode, r_zw, r_xsat, r_asat, r_aval} = ysb_out;

  always_comb begin
    res_nxt = '0;
    if (r_zw) begin
      res_nxt.zero_width = 1'b1;
    end else begin
      unique case (r_mode)
        REQ_LINEAR: begin
          res_nxt.interp_value = r_aval;
          res_nxt.saturated    = r_asat;
        end
        REQ_BILINEAR: begin
          res_nxt.interp_value = y_val;
          res_nxt.saturated    = r_xsat | y_sat;
        end
        default: res_nxt = '0;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= y_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/lbi_pass.sv
// ----------------------------------------------------------------------------
// lbi_pass: one pipelined weighted-average pass
// (f0*(hi-p) + f1*(p-lo)) / (hi-lo), truncated toward zero, saturated.
// Three arithmetic stages, an overflow compare, one quotient bit per stage
// and a saturation stage. Side data travels alongside unchanged.
// ----------------------------------------------------------------------------
module lbi_pass import lbi_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int SB_WIDTH   = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [DATA_WIDTH-1:0] f0,
  input  logic signed [DATA_WIDTH-1:0] f1,
  input  logic signed [DATA_WIDTH-1:0] p,
  input  logic signed [DATA_WIDTH-1:0] lo,
  input  logic signed [DATA_WIDTH-1:0] hi,
  input  logic [SB_WIDTH-1:0]          sb_in,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] val,
  output logic                         sat,
  output logic [SB_WIDTH-1:0]          sb_out
);

  localparam int W  = DATA_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * W + 1;
  localparam int SW = 2 * W + 2;

  // stage 1: distances and divisor
  logic                 s1_v_r;
  logic [W-1:0]         s1_f0_r, s1_f1_r;
  logic [DW-1:0]        s1_d1_r, s1_d0_r, s1_den_r;
  logic [SB_WIDTH-1:0]  s1_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_f0_r  <= f0;
      s1_f1_r  <= f1;
      s1_d1_r  <= {hi[W-1], hi} - {p[W-1], p};
      s1_d0_r  <= {p[W-1], p} - {lo[W-1], lo};
      s1_den_r <= {hi[W-1], hi} - {lo[W-1], lo};
      s1_sb_r  <= sb_in;
    end
  end

  // stage 2: magnitude products
  logic [W-1:0]  f0m, f1m;
  logic [DW-1:0] d1m, d0m, denm;

  assign f0m  = s1_f0_r[W-1]   ? (~s1_f0_r + 1'b1)  : s1_f0_r;
  assign f1m  = s1_f1_r[W-1]   ? (~s1_f1_r + 1'b1)  : s1_f1_r;
  assign d1m  = s1_d1_r[DW-1]  ? (~s1_d1_r + 1'b1)  : s1_d1_r;
  assign d0m  = s1_d0_r[DW-1]  ? (~s1_d0_r + 1'b1)  : s1_d0_r;
  assign denm = s1_den_r[DW-1] ? (~s1_den_r + 1'b1) : s1_den_r;

  logic                s2_v_r;
  logic [PW-1:0]       s2_ma_r, s2_mb_r;
  logic                s2_na_r, s2_nb_r, s2_dneg_r;
  logic [DW-1:0]       s2_dm_r;
  logic [SB_WIDTH-1:0] s2_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ma_r   <= PW'(f0m) * PW'(d1m);
      s2_mb_r   <= PW'(f1m) * PW'(d0m);
      s2_na_r   <= s1_f0_r[W-1] ^ s1_d1_r[DW-1];
      s2_nb_r   <= s1_f1_r[W-1] ^ s1_d0_r[DW-1];
      s2_dneg_r <= s1_den_r[DW-1];
      s2_dm_r   <= denm;
      s2_sb_r   <= s1_sb_r;
    end
  end

  // stage 3: signed sum of the two terms, back to sign and magnitude
  logic [SW-1:0] sa, sb, ssum;
  logic [PW-1:0] nm;

  assign sa   = s2_na_r ? (SW'(0) - SW'(s2_ma_r)) : SW'(s2_ma_r);
  assign sb   = s2_nb_r ? (SW'(0) - SW'(s2_mb_r)) : SW'(s2_mb_r);
  assign ssum = sa + sb;
  assign nm   = ssum[SW-1] ? PW'(SW'(0) - ssum) : PW'(ssum);

  logic                s3_v_r;
  logic [PW-1:0]       s3_nm_r;
  logic                s3_neg_r;
  logic [DW-1:0]       s3_dm_r;
  logic [SB_WIDTH-1:0] s3_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_nm_r  <= nm;
      s3_neg_r <= ssum[SW-1] ^ s2_dneg_r;
      s3_dm_r  <= s2_dm_r;
      s3_sb_r  <= s2_sb_r;
    end
  end

  // stage 4: flag quotients wider than W bits, then seed the divider
  logic                dv_v_r   [W+1];
  logic [PW-1:0]       dv_rem_r [W+1];
  logic [W-1:0]        dv_quo_r [W+1];
  logic [DW-1:0]       dv_dm_r  [W+1];
  logic                dv_neg_r [W+1];
  logic                dv_ov_r  [W+1];
  logic [SB_WIDTH-1:0] dv_sb_r  [W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= s3_nm_r;
      dv_quo_r[0] <= '0;
      dv_dm_r[0]  <= s3_dm_r;
      dv_neg_r[0] <= s3_neg_r;
      dv_ov_r[0]  <= s3_nm_r >= (PW'(s3_dm_r) << W);
      dv_sb_r[0]  <= s3_sb_r;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar k = 0; k < W; k++) begin : g_div
    localparam int B = W - 1 - k;
    logic [PW-1:0] shd;
    logic          ge;

    assign shd = PW'(dv_dm_r[k]) << B;
    assign ge  = dv_rem_r[k] >= shd;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k+1] <= ge ? (dv_rem_r[k] - shd) : dv_rem_r[k];
        dv_quo_r[k+1] <= dv_quo_r[k] | (W'(ge) << B);
        dv_dm_r[k+1]  <= dv_dm_r[k];
        dv_neg_r[k+1] <= dv_neg_r[k];
        dv_ov_r[k+1]  <= dv_ov_r[k];
        dv_sb_r[k+1]  <= dv_sb_r[k];
      end
    end
  end

  // final stage: apply sign and clip to W bits
  localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MAXNEG = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] q;
  logic         ov, negq;
  logic [W-1:0] val_nxt;
  logic         sat_nxt;

  assign q    = dv_quo_r[W];
  assign ov   = dv_ov_r[W];
  assign negq = dv_neg_r[W] && (ov || (q != '0));

  always_comb begin
    sat_nxt = 1'b0;
    val_nxt = q;
    if (negq) begin
      if (ov || (q > MAXNEG)) begin
        sat_nxt = 1'b1;
        val_nxt = MAXNEG;
      end else begin
        val_nxt = ~q + 1'b1;
      end
    end else if (ov || q[W-1]) begin
      sat_nxt = 1'b1;
      val_nxt = MAXPOS;
    end
  end

  logic                out_v_r;
  logic [W-1:0]        val_r;
  logic                sat_r;
  logic [SB_WIDTH-1:0] sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
      sat_r <= sat_nxt;
      sb_r  <= dv_sb_r[W];
    end
  end

  assign out_valid = out_v_r;
  assign val       = val_r;
  assign sat       = sat_r;
  assign sb_out    = sb_r;

endmodule

// File: bench/linear_bilinear_interpolator_top_test.sv
// ----------------------------------------------------------------------------
// linear_bilinear_interpolator_top_test: request/result check of the interpolator
// Drives linear, bilinear and unsupported requests with random idling on both
// channels, predicts each result in the bench and compares it in order.
// ----------------------------------------------------------------------------
module linear_bilinear_interpolator_top_test;
  import lbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 2 * (DATA_W + 5) + 1;
  localparam logic [1:0] REQ_SPARE2 = 2'd2;
  localparam logic [1:0] REQ_SPARE3 = 2'd3;
  localparam longint MAX_POS = (64'sd1 <<< (DATA_W - 1)) - 1;
  localparam longint MIN_NEG = -(64'sd1 <<< (DATA_W - 1));

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  lbi_req_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lbi_res_t out_data;

  lbi_res_t expected_results[$];
  int       fail_count = 0;
  bit       calm_phase = 1'b0;
  bit       hold_off = 1'b0;

  linear_bilinear_interpolator_top dut (.*);

  always #5 clk = ~clk;

  // One weighted-average pass, exact division truncating toward zero
  function automatic longint weigh_pass(longint f0, longint f1, longint p, longint lo,
                                        longint hi, ref bit sat);
    longint num;
    longint q;
    num = f0 * (hi - p) + f1 * (p - lo);
    q = num / (hi - lo);
    if (q > MAX_POS) begin
      sat = 1'b1;
      q = MAX_POS;
    end else if (q < MIN_NEG) begin
      sat = 1'b1;
      q = MIN_NEG;
    end
    return q;
  endfunction

  function automatic lbi_res_t interpolate(lbi_req_t r);
    lbi_res_t res;
    bit sat;
    longint a;
    longint b;
    longint v;
    res = '0;
    sat = 1'b0;
    v = 0;
    if (r.req_type == REQ_LINEAR) begin
      if (r.x_high == r.x_low) res.zero_width = 1'b1;
      else v = weigh_pass(r.f_00, r.f_10, r.x_pos, r.x_low, r.x_high, sat);
    end else if (r.req_type == REQ_BILINEAR) begin
      if (r.x_high == r.x_low || r.y_high == r.y_low) begin
        res.zero_width = 1'b1;
      end else begin
        a = weigh_pass(r.f_00, r.f_10, r.x_pos, r.x_low, r.x_high, sat);
        b = weigh_pass(r.f_01, r.f_11, r.x_pos, r.x_low, r.x_high, sat);
        v = weigh_pass(a, b, r.y_pos, r.y_low, r.y_high, sat);
      end
    end
    res.interp_value = v[DATA_W-1:0];
    res.saturated = sat;
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    logic [DATA_W-1:0] w;
    case ($urandom_range(0, 7))
      0: w = {1'b0, {(DATA_W-1){1'b1}}};
      1: w = {1'b1, {(DATA_W-1){1'b0}}};
      2: w = '0;
      3: w = DATA_W'($urandom_range(0, 1024)) - DATA_W'(512);
      default: w = DATA_W'($urandom);
    endcase
    return w;
  endfunction

  // Random request; usually a bracketed point with modest corners
  function automatic lbi_req_t rand_request();
    lbi_req_t r;
    int lo;
    int span;
    r.req_type = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1));
    r.x_pos = rand_word(); r.y_pos = rand_word();
    r.x_low = rand_word(); r.x_high = rand_word();
    r.y_low = rand_word(); r.y_high = rand_word();
    r.f_00 = rand_word(); r.f_10 = rand_word();
    r.f_01 = rand_word(); r.f_11 = rand_word();
    if ($urandom_range(0, 3) != 0) begin
      lo = $urandom_range(0, 60000) - 30000;
      span = $urandom_range(1, 2000);
      r.x_low = DATA_W'(lo); r.x_high = DATA_W'(lo + span);
      r.x_pos = DATA_W'(lo + $urandom_range(0, span));
      lo = $urandom_range(0, 60000) - 30000;
      span = $urandom_range(1, 2000);
      r.y_low = DATA_W'(lo); r.y_high = DATA_W'(lo + span);
      r.y_pos = DATA_W'(lo + $urandom_range(0, span));
      if ($urandom_range(0, 4) == 0) begin
        r.x_low = r.x_high + DATA_W'($urandom_range(1, 300));
      end
    end
    if ($urandom_range(0, 19) == 0) r.x_high = r.x_low;
    if ($urandom_range(0, 19) == 0) r.y_high = r.y_low;
    return r;
  endfunction

  // Offer one request and hold it until accepted; drop valid only while idling
  task automatic send_request(lbi_req_t r);
    while (!calm_phase && !hold_off && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results = {expected_results, interpolate(r)};
  endtask

  // Receiver idling and result check
  always @(posedge clk) begin
    lbi_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", out_data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.interp_value !== want.interp_value) begin
          $error("interp_value expected %0d got %0d", want.interp_value, out_data.interp_value);
          fail_count++;
        end
        if (out_data.zero_width !== want.zero_width) begin
          $error("zero_width expected %0d got %0d", want.zero_width, out_data.zero_width);
          fail_count++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated expected %0d got %0d", want.saturated, out_data.saturated);
          fail_count++;
        end
      end
    end
    out_stall <= hold_off || (!calm_phase && $urandom_range(0, 99) < 36);
  end

  task automatic make_request(output lbi_req_t r, input logic [1:0] kind,
                              input int x, int y, int x0, int x1, int y0, int y1,
                              int a, int b, int c, int d);
    r.req_type = kind;
    r.x_pos = DATA_W'(x); r.y_pos = DATA_W'(y);
    r.x_low = DATA_W'(x0); r.x_high = DATA_W'(x1);
    r.y_low = DATA_W'(y0); r.y_high = DATA_W'(y1);
    r.f_00 = DATA_W'(a); r.f_10 = DATA_W'(b);
    r.f_01 = DATA_W'(c); r.f_11 = DATA_W'(d);
  endtask

  // Extremes, zero width, reversed interval, extrapolation, clipping, spare modes
  task automatic test_directed();
    lbi_req_t r;
    make_request(r, REQ_LINEAR, 128, 0, 0, 256, 0, 0, 256, 512, 0, 0); send_request(r);
    make_request(r, REQ_LINEAR, 5, 0, 7, 7, 0, 0, 100, 200, 0, 0); send_request(r);
    make_request(r, REQ_BILINEAR, 5, 5, 0, 10, 3, 3, 1, 2, 3, 4); send_request(r);
    make_request(r, REQ_BILINEAR, 5, 5, 4, 4, 0, 10, 1, 2, 3, 4); send_request(r);
    make_request(r, REQ_LINEAR, 100, 0, 256, 0, 0, 0, -300, 700, 0, 0); send_request(r);
    make_request(r, REQ_LINEAR, 32767, 0, 0, 1, 0, 0, 0, 32767, 0, 0); send_request(r);
    make_request(r, REQ_LINEAR, -32768, 0, 0, 1, 0, 0, 0, 32767, 0, 0); send_request(r);
    make_request(r, REQ_LINEAR, -3, 0, 0, 2, 0, 0, 0, 1, 0, 0); send_request(r);
    make_request(r, REQ_BILINEAR, 32767, -32768, -32768, 32767, -32768, 32767,
                 -32768, 32767, 32767, -32768); send_request(r);
    make_request(r, REQ_BILINEAR, 300, 300, 0, 256, 0, 256, 1000, 2000, 3000, 4000);
    send_request(r);
    make_request(r, REQ_BILINEAR, 77, -99, 0, 256, 0, -256, -1, 1, -32768, 32767);
    send_request(r);
    make_request(r, REQ_SPARE2, 1, 1, 0, 2, 0, 2, 9, 9, 9, 9); send_request(r);
    make_request(r, REQ_SPARE3, -1, -1, 0, 0, 0, 0, -1, -1, -1, -1); send_request(r);
    make_request(r, REQ_LINEAR, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1); send_request(r);
    make_request(r, REQ_BILINEAR, -1, -1, 0, -1, 0, -1, -1, -1, -1, -1); send_request(r);
  endtask

  task automatic test_random(int count);
    repeat (count) send_request(rand_request());
  endtask

  // Back-to-back with no idling
  task automatic test_streaming(int count);
    calm_phase = 1'b1;
    repeat (count) send_request(rand_request());
    calm_phase = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, so the pipeline fills
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (4 * LATENCY) send_request(rand_request());
    join
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_backpressure();
    test_streaming(300);
    test_random(550);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
